/* rtl/core/covering_window_id_range_assert.svh */
// Assertion macros for the covering window id range block.
`ifndef COVERING_WINDOW_ID_RANGE_ASSERT_SVH
`define COVERING_WINDOW_ID_RANGE_ASSERT_SVH
`ifndef ASSERT_OFF
`define CWIR_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CWIR_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CWIR_ASSERT(name, clk, rst, prop, msg)
`define CWIR_ASSERT_ALWAYS(name, clk, prop, msg)
`endif
`endif

/* rtl/core/cwir_pkg.sv */
// Package: constants, register indexes and status codes of the covering window id range block.
package cwir_pkg;

   localparam int MAX_RUN_DEF = 64;
   localparam int DATA_W      = 32;
   localparam int ADDR_W      = 4;
   localparam int DIV_STEPS   = 32;
   localparam int DIV_CNT_W   = 5;

   typedef enum logic [1:0] {
      REG_WINDOW_LENGTH    = 2'd0,
      REG_STRIDE           = 2'd1,
      REG_WINDOW_COUNT     = 2'd2,
      REG_REFERENCE_LENGTH = 2'd3
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_NO_COVER  = 3'd1,
      ST_ZERO_SPAN = 3'd2,
      ST_TOO_LONG  = 3'd3,
      ST_OUTSIDE   = 3'd4,
      ST_TRUNC     = 3'd5
   } status_type;

endpackage

/* rtl/core/covering_window_id_range.sv */
// Top level: window id range covering an occurrence, on a shared serial divider.
//
//  channel  | handshake             | payload
//  req      | req_valid/req_ready   | req_occurrence_start, req_span
//  rsp      | rsp_valid/rsp_ready   | rsp_window_id, rsp_status, rsp_last
//  csr      | csr_psel/csr_penable  | csr_paddr, csr_pwdata, csr_prdata
//
// A valid occurrence passes the check state, two divisions on the shared divider (ceil and floor
// by the stride, one quotient bit a cycle) and the range state, then gives one result
// per cycle while rsp_ready is high.
// A rejected occurrence skips the divider: after the check state comes its status result.
// req_ready rises in the cycle after the last result is taken; only rsp_ready stalls delay it.
// Reset is synchronous, active high; the CSRs return to 1, the state to idle.
`include "covering_window_id_range_assert.svh"

module covering_window_id_range #(
   parameter int MaxRun = cwir_pkg::MAX_RUN_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [cwir_pkg::DATA_W-1:0]   req_occurrence_start,
   input  logic [cwir_pkg::DATA_W-1:0]   req_span,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [cwir_pkg::DATA_W-1:0]   rsp_window_id,
   output cwir_pkg::status_type          rsp_status,
   output logic                          rsp_last,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [cwir_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [cwir_pkg::DATA_W-1:0]   csr_pwdata,
   output logic [cwir_pkg::DATA_W-1:0]   csr_prdata,
   output logic                          csr_pready
);
   import cwir_pkg::*;

   localparam int LeftW = $clog2(MaxRun + 1);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_CHECK = 6'b000010,
      S_DIV1  = 6'b000100,
      S_DIV2  = 6'b001000,
      S_EVAL  = 6'b010000,
      S_EMIT  = 6'b100000
   } state_type;

   state_type                  state_ff, state_in;
   logic [DATA_W-1:0]          wl_ff, wl_in;
   logic [DATA_W-1:0]          stride_ff, stride_in;
   logic [DATA_W-1:0]          wc_ff, wc_in;
   logic [DATA_W-1:0]          rl_ff, rl_in;
   logic [DATA_W-1:0]          start_ff, start_in;
   logic [DATA_W-1:0]          span_ff, span_in;
   logic [DATA_W-1:0]          sd_ff, sd_in;
   logic [2*DATA_W-1:0]        prod_ff, prod_in;
   logic [DATA_W-1:0]          rem_ff, rem_in;
   logic [DATA_W-1:0]          quo_ff, quo_in;
   logic [DIV_CNT_W-1:0]       cnt_ff, cnt_in;
   logic [DATA_W-1:0]          first_ff, first_in;
   logic [DATA_W-1:0]          last_id_ff, last_id_in;
   logic [DATA_W-1:0]          id_ff, id_in;
   logic [LeftW-1:0]           left_ff, left_in;
   status_type                 final_ff, final_in;

   logic                       csr_wr;
   reg_index_type              csr_idx;
   logic [DATA_W-1:0]          sd_eff, wc_eff;
   logic [DATA_W:0]            occ_end, min_start_w, count;
   logic [DATA_W-1:0]          max_start;
   logic [DATA_W:0]            shifted;
   logic [DATA_W+1:0]          diff;
   logic                       ge;
   logic [DATA_W-1:0]          rem_step, quo_step;
   logic                       div_done;

   assign csr_pready = 1'b1;
   assign csr_idx    = reg_index_type'(csr_paddr[ADDR_W-1:2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      unique case (csr_idx)
         REG_WINDOW_LENGTH:    csr_prdata = wl_ff;
         REG_STRIDE:           csr_prdata = stride_ff;
         REG_WINDOW_COUNT:     csr_prdata = wc_ff;
         REG_REFERENCE_LENGTH: csr_prdata = rl_ff;
         default:              csr_prdata = '0;
      endcase
   end

   always_comb begin
      wl_in     = wl_ff;
      stride_in = stride_ff;
      wc_in     = wc_ff;
      rl_in     = rl_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            REG_WINDOW_LENGTH:    wl_in     = csr_pwdata;
            REG_STRIDE:           stride_in = csr_pwdata;
            REG_WINDOW_COUNT:     wc_in     = csr_pwdata;
            REG_REFERENCE_LENGTH: rl_in     = csr_pwdata;
            default:              wl_in     = wl_ff;
         endcase
      end
   end

   // shared restoring divider step
   assign shifted  = {rem_ff, quo_ff[DATA_W-1]};
   assign diff     = {1'b0, shifted} - {2'b00, sd_ff};
   assign ge       = !diff[DATA_W+1];
   assign rem_step = ge ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
   assign quo_step = {quo_ff[DATA_W-2:0], ge};
   assign div_done = (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1));

   assign sd_eff      = (stride_ff == '0) ? DATA_W'(1) : stride_ff;
   assign wc_eff      = (wc_ff == '0) ? DATA_W'(1) : wc_ff;
   assign occ_end     = {1'b0, start_ff} + {1'b0, span_ff};
   assign min_start_w = (occ_end > {1'b0, wl_ff}) ? (occ_end - {1'b0, wl_ff}) : '0;
   assign max_start   = ((prod_ff[2*DATA_W-1:DATA_W] != '0) ||
                         (prod_ff[DATA_W-1:0] > start_ff)) ? start_ff : prod_ff[DATA_W-1:0];
   assign count       = {1'b0, last_id_ff} - {1'b0, first_ff} + (DATA_W+1)'(1);

   always_comb begin
      state_in   = state_ff;
      start_in   = start_ff;
      span_in    = span_ff;
      sd_in      = sd_ff;
      prod_in    = prod_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      cnt_in     = cnt_ff;
      first_in   = first_ff;
      last_id_in = last_id_ff;
      id_in      = id_ff;
      left_in    = left_ff;
      final_in   = final_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               start_in = req_occurrence_start;
               span_in  = req_span;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            sd_in    = sd_eff;
            prod_in  = (2*DATA_W)'(wc_eff - DATA_W'(1)) * (2*DATA_W)'(sd_eff);
            rem_in   = '0;
            quo_in   = min_start_w[DATA_W-1:0];
            cnt_in   = '0;
            left_in  = '0;
            final_in = ST_OK;
            priority if (span_ff == '0) begin
               final_in = ST_ZERO_SPAN;
               state_in = S_EMIT;
            end else if (span_ff > wl_ff) begin
               final_in = ST_TOO_LONG;
               state_in = S_EMIT;
            end else if ((start_ff >= rl_ff) || (occ_end > {1'b0, rl_ff})) begin
               final_in = ST_OUTSIDE;
               state_in = S_EMIT;
            end else begin
               state_in = S_DIV1;
            end
         end
         S_DIV1: begin
            rem_in = rem_step;
            quo_in = quo_step;
            cnt_in = cnt_ff + DIV_CNT_W'(1);
            if (div_done) begin
               // ceiling: bump the quotient on a nonzero remainder
               first_in = quo_step + DATA_W'(rem_step != '0);
               rem_in   = '0;
               quo_in   = max_start;
               cnt_in   = '0;
               state_in = S_DIV2;
            end
         end
         S_DIV2: begin
            rem_in = rem_step;
            quo_in = quo_step;
            cnt_in = cnt_ff + DIV_CNT_W'(1);
            if (div_done) begin
               last_id_in = quo_step;
               state_in   = S_EVAL;
            end
         end
         S_EVAL: begin
            id_in    = first_ff;
            state_in = S_EMIT;
            priority if (first_ff > last_id_ff) begin
               left_in  = '0;
               final_in = ST_NO_COVER;
            end else if (count > (DATA_W+1)'(MaxRun)) begin
               left_in  = LeftW'(MaxRun - 1);
               final_in = ST_TRUNC;
            end else begin
               left_in  = count[LeftW-1:0];
               final_in = ST_OK;
            end
         end
         S_EMIT: begin
            if (rsp_ready) begin
               if (rsp_last) begin
                  state_in = S_IDLE;
               end else begin
                  left_in = left_ff - LeftW'(1);
                  id_in   = id_ff + DATA_W'(1);
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req_ready     = (state_ff == S_IDLE);
   assign rsp_valid     = (state_ff == S_EMIT);
   assign rsp_window_id = (left_ff != '0) ? id_ff : '0;
   assign rsp_status    = (left_ff != '0) ? ST_OK : final_ff;
   assign rsp_last      = (left_ff == '0) || ((left_ff == LeftW'(1)) && (final_ff == ST_OK));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         wl_ff     <= DATA_W'(1);
         stride_ff <= DATA_W'(1);
         wc_ff     <= DATA_W'(1);
         rl_ff     <= DATA_W'(1);
         left_ff   <= '0;
         final_ff  <= ST_OK;
      end else begin
         state_ff  <= state_in;
         wl_ff     <= wl_in;
         stride_ff <= stride_in;
         wc_ff     <= wc_in;
         rl_ff     <= rl_in;
         left_ff   <= left_in;
         final_ff  <= final_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff   <= start_in;
      span_ff    <= span_in;
      sd_ff      <= sd_in;
      prod_ff    <= prod_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      cnt_ff     <= cnt_in;
      first_ff   <= first_in;
      last_id_ff <= last_id_in;
      id_ff      <= id_in;
   end

   `CWIR_ASSERT(a_idle_no_rsp, clock, reset, req_ready |-> !rsp_valid, "rsp_valid while idle")
   `CWIR_ASSERT(a_err_is_last, clock, reset, (rsp_valid && rsp_status != ST_OK) |-> rsp_last, "status result not last")
   `CWIR_ASSERT(a_id_ascends, clock, reset, (rsp_valid && rsp_ready && !rsp_last) |=> (rsp_valid && (rsp_status != ST_OK || rsp_window_id == $past(rsp_window_id) + 32'd1)), "window ids not consecutive")
   `CWIR_ASSERT(a_busy_after_req, clock, reset, (req_valid && req_ready) |=> !req_ready, "ready right after accept")
   `CWIR_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> (req_ready && !rsp_valid), "not idle after reset")

endmodule
